// File: rtl/rrc_pkg.sv
package rrc_pkg;

	localparam int COORD_W = 20;
	localparam int SIZE_W  = 19;
	localparam int ANGLE_W = 9;
	localparam int IDX_W   = 7;
	localparam int TRIG_Q  = 14;
	localparam int TMAG_W  = 15;

	localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
	localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
	localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
	localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

	// quadrant-folded table address plus sign
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             neg;
	} trig_sel_t;

	// sin(d deg) * 2^14, d = 0..90
	localparam logic [TMAG_W-1:0] SIN_Q14 [0:90] = '{
		15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
		15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
		15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
		15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
		15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
		15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
		15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
		15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
		15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
		15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
		15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
		15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
		15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
		15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
		15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
		15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
		15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
		15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
		15'd16384
	};

	// fold an angle in 0..359 onto the first quadrant
	function automatic trig_sel_t fold_angle(input logic [ANGLE_W-1:0] a);
		trig_sel_t r;
		logic [ANGLE_W-1:0] t;
		t = '0;
		r.neg = 1'b0;
		if (a <= DEG_90) begin
			t = a;
		end else if (a <= DEG_180) begin
			t = DEG_180 - a;
		end else if (a <= DEG_270) begin
			t = a - DEG_180;
			r.neg = 1'b1;
		end else begin
			t = DEG_360 - a;
			r.neg = 1'b1;
		end
		r.idx = t[IDX_W-1:0];
		return r;
	endfunction

endpackage

// File: rtl/rotated_rectangle_corners.sv
// rotated rectangle corners
//
// one item per start pulse: anchor, size, pivot offset and an angle in whole
// degrees; the block returns the four corners rotated clockwise (screen y
// down) about the anchor, order top-left, top-right, bottom-left, bottom-right
//
// input: an item is taken at a rising edge with start high and busy low;
// busy is held low, so a new item may enter in every cycle
// output: done is high for exactly one cycle with the eight corner
// coordinates, which are valid only in that cycle
//
// throughput one item per cycle, carried by the five register stages:
//   s1 angle fold and corner offsets, s2 sine/cosine table and rescale,
//   s3 eight products, s4 sum and round, s5 anchor add and saturate
//
// reset clears the stage valid bits only; items in flight are dropped
// the receiver cannot stall, so the pipeline never stops
module rotated_rectangle_corners #(
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [rrc_pkg::COORD_W-1:0]  anchor_x,
	input  logic signed [rrc_pkg::COORD_W-1:0]  anchor_y,
	input  logic        [rrc_pkg::SIZE_W-1:0]   rect_width,
	input  logic        [rrc_pkg::SIZE_W-1:0]   rect_height,
	input  logic signed [rrc_pkg::COORD_W-1:0]  pivot_x,
	input  logic signed [rrc_pkg::COORD_W-1:0]  pivot_y,
	input  logic        [rrc_pkg::ANGLE_W-1:0]  angle_deg,
	output logic                                done,
	output logic signed [rrc_pkg::COORD_W-1:0]  top_left_x,
	output logic signed [rrc_pkg::COORD_W-1:0]  top_left_y,
	output logic signed [rrc_pkg::COORD_W-1:0]  top_right_x,
	output logic signed [rrc_pkg::COORD_W-1:0]  top_right_y,
	output logic signed [rrc_pkg::COORD_W-1:0]  bottom_left_x,
	output logic signed [rrc_pkg::COORD_W-1:0]  bottom_left_y,
	output logic signed [rrc_pkg::COORD_W-1:0]  bottom_right_x,
	output logic signed [rrc_pkg::COORD_W-1:0]  bottom_right_y
);

	localparam int CW = rrc_pkg::COORD_W;
	// offsets from the pivot need one more bit than a coordinate
	localparam int UW = CW + 1;
	// trig magnitude reaches 2^T, signed value needs T+2 bits
	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int PW = UW + TW;
	localparam int SW = PW + 1;
	localparam int RW = SW - TRIG_FRAC_BITS;
	localparam int AW = RW + 1;

	// table rescale from Q14 to TRIG_FRAC_BITS
	localparam int SH_UP = (TRIG_FRAC_BITS >= rrc_pkg::TRIG_Q) ?
		TRIG_FRAC_BITS - rrc_pkg::TRIG_Q : 0;
	localparam int SH_DN = (TRIG_FRAC_BITS < rrc_pkg::TRIG_Q) ?
		rrc_pkg::TRIG_Q - TRIG_FRAC_BITS : 0;
	localparam int MW = rrc_pkg::TMAG_W + SH_UP + 1;
	localparam logic [MW-1:0] MAG_HALF = MW'((64'd1 << SH_DN) >> 1);
	localparam logic signed [SW-1:0] RND_HALF = SW'((64'd1 << TRIG_FRAC_BITS) >> 1);

	localparam logic signed [AW-1:0] SAT_MAX = AW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic signed [AW-1:0] SAT_MIN = -AW'(64'd1 << (CW - 1));

	logic accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// ---------------------------------------------------------------------
	// stage 1: angle fold for sine and cosine, corner offsets from pivot
	// ---------------------------------------------------------------------
	logic [rrc_pkg::ANGLE_W-1:0] ang_mod;
	logic [rrc_pkg::ANGLE_W-1:0] ang_cos_raw;
	logic [rrc_pkg::ANGLE_W-1:0] ang_cos;
	logic signed [UW-1:0] npx;
	logic signed [UW-1:0] npy;

	logic                    v_s1;
	rrc_pkg::trig_sel_t      sin_sel_s1;
	rrc_pkg::trig_sel_t      cos_sel_s1;
	logic signed [UW-1:0]    ux_s1 [2];
	logic signed [UW-1:0]    uy_s1 [2];
	logic signed [CW-1:0]    ax_s1;
	logic signed [CW-1:0]    ay_s1;

	always_comb begin
		ang_mod = (angle_deg >= rrc_pkg::DEG_360) ? angle_deg - rrc_pkg::DEG_360 : angle_deg;
		ang_cos_raw = ang_mod + rrc_pkg::DEG_90;
		ang_cos = (ang_cos_raw >= rrc_pkg::DEG_360) ?
			ang_cos_raw - rrc_pkg::DEG_360 : ang_cos_raw;
		npx = -{pivot_x[CW-1], pivot_x};
		npy = -{pivot_y[CW-1], pivot_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		sin_sel_s1 <= rrc_pkg::fold_angle(ang_mod);
		cos_sel_s1 <= rrc_pkg::fold_angle(ang_cos);
		ux_s1[0]   <= npx;
		ux_s1[1]   <= $signed({2'b00, rect_width}) + npx;
		uy_s1[0]   <= npy;
		uy_s1[1]   <= $signed({2'b00, rect_height}) + npy;
		ax_s1      <= anchor_x;
		ay_s1      <= anchor_y;
	end

	// ---------------------------------------------------------------------
	// stage 2: table lookup, rescale, sign
	// ---------------------------------------------------------------------
	logic [MW-1:0] sin_mag_w;
	logic [MW-1:0] cos_mag_w;
	logic [TW-1:0] sin_mag;
	logic [TW-1:0] cos_mag;

	logic                 v_s2;
	logic signed [TW-1:0] sin_s2;
	logic signed [TW-1:0] cos_s2;
	logic signed [UW-1:0] ux_s2 [2];
	logic signed [UW-1:0] uy_s2 [2];
	logic signed [CW-1:0] ax_s2;
	logic signed [CW-1:0] ay_s2;

	always_comb begin
		sin_mag_w = ((MW'(rrc_pkg::SIN_Q14[sin_sel_s1.idx]) << SH_UP) + MAG_HALF) >> SH_DN;
		cos_mag_w = ((MW'(rrc_pkg::SIN_Q14[cos_sel_s1.idx]) << SH_UP) + MAG_HALF) >> SH_DN;
		sin_mag   = TW'(sin_mag_w);
		cos_mag   = TW'(cos_mag_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sin_s2 <= sin_sel_s1.neg ? -$signed(sin_mag) : $signed(sin_mag);
		cos_s2 <= cos_sel_s1.neg ? -$signed(cos_mag) : $signed(cos_mag);
		ux_s2  <= ux_s1;
		uy_s2  <= uy_s1;
		ax_s2  <= ax_s1;
		ay_s2  <= ay_s1;
	end

	// ---------------------------------------------------------------------
	// stage 3: the eight distinct products
	// ---------------------------------------------------------------------
	logic                 v_s3;
	logic signed [PW-1:0] xc_s3 [2];
	logic signed [PW-1:0] xs_s3 [2];
	logic signed [PW-1:0] yc_s3 [2];
	logic signed [PW-1:0] ys_s3 [2];
	logic signed [CW-1:0] ax_s3;
	logic signed [CW-1:0] ay_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			xc_s3[i] <= ux_s2[i] * cos_s2;
			xs_s3[i] <= ux_s2[i] * sin_s2;
			yc_s3[i] <= uy_s2[i] * cos_s2;
			ys_s3[i] <= uy_s2[i] * sin_s2;
		end
		ax_s3 <= ax_s2;
		ay_s3 <= ay_s2;
	end

	// ---------------------------------------------------------------------
	// stage 4: exact sums, round to nearest with ties up
	// corner k: bit 0 picks the width side, bit 1 the height side
	// ---------------------------------------------------------------------
	logic signed [SW-1:0] sum_x [4];
	logic signed [SW-1:0] sum_y [4];

	logic                 v_s4;
	logic signed [RW-1:0] rx_s4 [4];
	logic signed [RW-1:0] ry_s4 [4];
	logic signed [CW-1:0] ax_s4;
	logic signed [CW-1:0] ay_s4;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sum_x[k] = SW'(xc_s3[k % 2]) - SW'(ys_s3[k / 2]) + RND_HALF;
			sum_y[k] = SW'(xs_s3[k % 2]) + SW'(yc_s3[k / 2]) + RND_HALF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			rx_s4[k] <= sum_x[k][SW-1:TRIG_FRAC_BITS];
			ry_s4[k] <= sum_y[k][SW-1:TRIG_FRAC_BITS];
		end
		ax_s4 <= ax_s3;
		ay_s4 <= ay_s3;
	end

	// ---------------------------------------------------------------------
	// stage 5: add anchor, clamp to coordinate range, output registers
	// ---------------------------------------------------------------------
	logic signed [AW-1:0] px_full [4];
	logic signed [AW-1:0] py_full [4];
	logic signed [CW-1:0] px_sat  [4];
	logic signed [CW-1:0] py_sat  [4];

	logic                 v_s5;
	logic signed [CW-1:0] cx_s5 [4];
	logic signed [CW-1:0] cy_s5 [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			px_full[k] = AW'(ax_s4) + AW'(rx_s4[k]);
			py_full[k] = AW'(ay_s4) + AW'(ry_s4[k]);
			if (px_full[k] > SAT_MAX) begin
				px_sat[k] = SAT_MAX[CW-1:0];
			end else if (px_full[k] < SAT_MIN) begin
				px_sat[k] = SAT_MIN[CW-1:0];
			end else begin
				px_sat[k] = px_full[k][CW-1:0];
			end
			if (py_full[k] > SAT_MAX) begin
				py_sat[k] = SAT_MAX[CW-1:0];
			end else if (py_full[k] < SAT_MIN) begin
				py_sat[k] = SAT_MIN[CW-1:0];
			end else begin
				py_sat[k] = py_full[k][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		cx_s5 <= px_sat;
		cy_s5 <= py_sat;
	end

	assign done           = v_s5;
	assign top_left_x     = cx_s5[0];
	assign top_left_y     = cy_s5[0];
	assign top_right_x    = cx_s5[1];
	assign top_right_y    = cy_s5[1];
	assign bottom_left_x  = cx_s5[2];
	assign bottom_left_y  = cy_s5[2];
	assign bottom_right_x = cx_s5[3];
	assign bottom_right_y = cy_s5[3];

endmodule

// File: test/rect_corner_checker.sv
`timescale 1ns / 1ps

module rect_corner_checker #(
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic signed [rrc_pkg::COORD_W-1:0]  anchor_x,
	input  logic signed [rrc_pkg::COORD_W-1:0]  anchor_y,
	input  logic        [rrc_pkg::SIZE_W-1:0]   rect_width,
	input  logic        [rrc_pkg::SIZE_W-1:0]   rect_height,
	input  logic signed [rrc_pkg::COORD_W-1:0]  pivot_x,
	input  logic signed [rrc_pkg::COORD_W-1:0]  pivot_y,
	input  logic        [rrc_pkg::ANGLE_W-1:0]  angle_deg,
	input  logic                                done,
	input  logic signed [rrc_pkg::COORD_W-1:0]  top_left_x,
	input  logic signed [rrc_pkg::COORD_W-1:0]  top_left_y,
	input  logic signed [rrc_pkg::COORD_W-1:0]  top_right_x,
	input  logic signed [rrc_pkg::COORD_W-1:0]  top_right_y,
	input  logic signed [rrc_pkg::COORD_W-1:0]  bottom_left_x,
	input  logic signed [rrc_pkg::COORD_W-1:0]  bottom_left_y,
	input  logic signed [rrc_pkg::COORD_W-1:0]  bottom_right_x,
	input  logic signed [rrc_pkg::COORD_W-1:0]  bottom_right_y,
	output int                                  failures,
	output int                                  outstanding
);
	import rrc_pkg::*;

	localparam longint COORD_HI = (longint'(1) << (COORD_W - 1)) - 1;
	localparam longint COORD_LO = -(longint'(1) << (COORD_W - 1));

	// sin(d deg) in Q2.14, d = 0..90
	localparam int SINE_Q14 [0:90] = '{
		0,     286,   572,   857,   1143,  1428,  1713,  1997,  2280,  2563,
		2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
		5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
		8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860,  10087, 10311,
		10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
		12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
		14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
		15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
		16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
		16384
	};

	typedef struct {
		logic signed [COORD_W-1:0] anchor_x;
		logic signed [COORD_W-1:0] anchor_y;
		logic        [SIZE_W-1:0]  width;
		logic        [SIZE_W-1:0]  height;
		logic signed [COORD_W-1:0] pivot_x;
		logic signed [COORD_W-1:0] pivot_y;
		logic        [ANGLE_W-1:0] angle;
	} rect_item_t;

	// x/y pairs in order top-left, top-right, bottom-left, bottom-right
	typedef logic [7:0][COORD_W-1:0] corner_set_t;

	corner_set_t corners_due[$];
	corner_set_t corners_exp;
	corner_set_t corners_got;
	rect_item_t  rect_in;
	int          fail_count = 0;
	int          results_seen = 0;
	int          pending_count = 0;
	string       coord_label;

	assign failures    = fail_count;
	assign outstanding = pending_count;

	task automatic report_mismatch(input string msg);
		$display("[%0t] corner mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	// sine at TRIG_FRAC_BITS fraction bits, any angle in 0..719
	function automatic longint scaled_sine(input int unsigned deg);
		int unsigned d;
		int unsigned idx;
		bit          neg;
		longint      mag;
		int          sh;
		d   = deg % 360;
		neg = 1'b0;
		if (d <= 90) begin
			idx = d;
		end else if (d <= 180) begin
			idx = 180 - d;
		end else if (d <= 270) begin
			idx = d - 180;
			neg = 1'b1;
		end else begin
			idx = 360 - d;
			neg = 1'b1;
		end
		mag = SINE_Q14[idx];
		if (TRIG_FRAC_BITS >= 14) begin
			sh  = TRIG_FRAC_BITS - 14;
			mag = mag <<< sh;
		end else begin
			sh  = 14 - TRIG_FRAC_BITS;
			mag = (mag + ((longint'(1) << sh) >>> 1)) >>> sh;
		end
		return neg ? -mag : mag;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
		longint c;
		c = v;
		if (c > COORD_HI) c = COORD_HI;
		if (c < COORD_LO) c = COORD_LO;
		return c[COORD_W-1:0];
	endfunction

	// four corners rotated about the anchor, rounded half up, saturated
	function automatic corner_set_t rotate_rect(input rect_item_t it);
		corner_set_t r;
		longint      sn;
		longint      cs;
		longint      ux;
		longint      uy;
		longint      half;
		int unsigned ang;
		half = longint'(1) << (TRIG_FRAC_BITS - 1);
		ang  = int'(it.angle) % 360;
		sn   = scaled_sine(ang);
		cs   = scaled_sine(ang + 90);
		for (int k = 0; k < 4; k++) begin
			ux = -longint'(it.pivot_x) + (((k & 1) != 0) ? longint'(it.width) : longint'(0));
			uy = -longint'(it.pivot_y) + (((k & 2) != 0) ? longint'(it.height) : longint'(0));
			r[2*k]   = clamp_coord(longint'(it.anchor_x)
				+ ((ux * cs - uy * sn + half) >>> TRIG_FRAC_BITS));
			r[2*k+1] = clamp_coord(longint'(it.anchor_y)
				+ ((ux * sn + uy * cs + half) >>> TRIG_FRAC_BITS));
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				rect_in.anchor_x = anchor_x;
				rect_in.anchor_y = anchor_y;
				rect_in.width    = rect_width;
				rect_in.height   = rect_height;
				rect_in.pivot_x  = pivot_x;
				rect_in.pivot_y  = pivot_y;
				rect_in.angle    = angle_deg;
				// expected corners wait at the tail until their result shows up
				corners_due = {corners_due, rotate_rect(rect_in)};
			end
			if (done) begin
				if (corners_due.size() == 0) begin
					report_mismatch($sformatf("result %0d with no item waiting", results_seen));
				end else begin
					corners_exp    = corners_due.pop_front();
					corners_got[0] = top_left_x;
					corners_got[1] = top_left_y;
					corners_got[2] = top_right_x;
					corners_got[3] = top_right_y;
					corners_got[4] = bottom_left_x;
					corners_got[5] = bottom_left_y;
					corners_got[6] = bottom_right_x;
					corners_got[7] = bottom_right_y;
					for (int k = 0; k < 8; k++) begin
						case (k)
							0: coord_label = "top_left_x";
							1: coord_label = "top_left_y";
							2: coord_label = "top_right_x";
							3: coord_label = "top_right_y";
							4: coord_label = "bottom_left_x";
							5: coord_label = "bottom_left_y";
							6: coord_label = "bottom_right_x";
							default: coord_label = "bottom_right_y";
						endcase
						if (corners_got[k] !== corners_exp[k]) begin
							report_mismatch($sformatf("result %0d %s got %0d expected %0d",
								results_seen, coord_label, $signed(corners_got[k]),
								$signed(corners_exp[k])));
						end
					end
				end
				results_seen++;
			end
			pending_count <= corners_due.size();
		end
	end

endmodule

// File: test/rotated_rectangle_corners_tb.sv
`timescale 1ns / 1ps

// stimulus and verdict for the rotated rectangle corner block; all
// prediction and comparison lives in the checker beside the block
module rotated_rectangle_corners_tb;
	import rrc_pkg::*;

	localparam int TRIG_FRAC    = 14;
	localparam int RANDOM_ITEMS = 450;
	localparam int CYCLE_LIMIT  = 200000;
	// five register stages plus margin
	localparam int DRAIN_CYCLES = 12;
	localparam int IDLE_PCT     = 38;

	localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic        [SIZE_W-1:0]  SMAX = '1;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       start       = 1'b0;
	logic signed [COORD_W-1:0]  anchor_x    = '0;
	logic signed [COORD_W-1:0]  anchor_y    = '0;
	logic        [SIZE_W-1:0]   rect_width  = '0;
	logic        [SIZE_W-1:0]   rect_height = '0;
	logic signed [COORD_W-1:0]  pivot_x     = '0;
	logic signed [COORD_W-1:0]  pivot_y     = '0;
	logic        [ANGLE_W-1:0]  angle_deg   = '0;
	logic                       busy;
	logic                       done;
	logic signed [COORD_W-1:0]  top_left_x;
	logic signed [COORD_W-1:0]  top_left_y;
	logic signed [COORD_W-1:0]  top_right_x;
	logic signed [COORD_W-1:0]  top_right_y;
	logic signed [COORD_W-1:0]  bottom_left_x;
	logic signed [COORD_W-1:0]  bottom_left_y;
	logic signed [COORD_W-1:0]  bottom_right_x;
	logic signed [COORD_W-1:0]  bottom_right_y;

	int failures;
	int outstanding;
	int cycles = 0;
	// when clear, items go back to back
	bit gaps_on = 1'b1;

	rotated_rectangle_corners #(
		.TRIG_FRAC_BITS(TRIG_FRAC)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.anchor_x      (anchor_x),
		.anchor_y      (anchor_y),
		.rect_width    (rect_width),
		.rect_height   (rect_height),
		.pivot_x       (pivot_x),
		.pivot_y       (pivot_y),
		.angle_deg     (angle_deg),
		.done          (done),
		.top_left_x    (top_left_x),
		.top_left_y    (top_left_y),
		.top_right_x   (top_right_x),
		.top_right_y   (top_right_y),
		.bottom_left_x (bottom_left_x),
		.bottom_left_y (bottom_left_y),
		.bottom_right_x(bottom_right_x),
		.bottom_right_y(bottom_right_y)
	);

	// watches both channels, predicts every item and counts mismatches
	rect_corner_checker #(
		.TRIG_FRAC_BITS(TRIG_FRAC)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.anchor_x      (anchor_x),
		.anchor_y      (anchor_y),
		.rect_width    (rect_width),
		.rect_height   (rect_height),
		.pivot_x       (pivot_x),
		.pivot_y       (pivot_y),
		.angle_deg     (angle_deg),
		.done          (done),
		.top_left_x    (top_left_x),
		.top_left_y    (top_left_y),
		.top_right_x   (top_right_x),
		.top_right_y   (top_right_y),
		.bottom_left_x (bottom_left_x),
		.bottom_left_y (bottom_left_y),
		.bottom_right_x(bottom_right_x),
		.bottom_right_y(bottom_right_y),
		.failures      (failures),
		.outstanding   (outstanding)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// reset held low from time zero, released once
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog: a hung handshake or a lost result ends up here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// present one item, with a random idle gap in front of it, and hold it
	// until the block takes it
	task automatic send_rect(
		input logic signed [COORD_W-1:0] ax, ay,
		input logic        [SIZE_W-1:0]  w, h,
		input logic signed [COORD_W-1:0] px, py,
		input logic        [ANGLE_W-1:0] ang
	);
		while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		anchor_x    <= ax;
		anchor_y    <= ay;
		rect_width  <= w;
		rect_height <= h;
		pivot_x     <= px;
		pivot_y     <= py;
		angle_deg   <= ang;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// mostly on-screen sprites with the pivot near the rectangle, plus raw
	// bit noise and huge rectangles that drive the corners into saturation
	task automatic send_random_rect();
		logic signed [COORD_W-1:0] ax, ay, px, py;
		logic        [SIZE_W-1:0]  w, h;
		logic        [ANGLE_W-1:0] ang;
		int unsigned               mode;
		mode = $urandom_range(0, 7);
		if ($urandom_range(0, 7) == 0) begin
			// angles past a full turn wrap around
			ang = $urandom_range(360, (1 << ANGLE_W) - 1);
		end else begin
			ang = $urandom_range(0, 359);
		end
		case (mode)
			0: begin
				ax  = $urandom();
				ay  = $urandom();
				w   = $urandom();
				h   = $urandom();
				px  = $urandom();
				py  = $urandom();
				ang = $urandom();
			end
			1: begin
				ax = $urandom_range(0, 8191) - 4096;
				ay = $urandom_range(0, 8191) - 4096;
				w  = $urandom_range(SMAX / 2, SMAX);
				h  = $urandom_range(SMAX / 2, SMAX);
				px = $urandom_range(0, w);
				py = $urandom_range(0, h);
			end
			default: begin
				ax = $urandom_range(0, 131071) - 65536;
				ay = $urandom_range(0, 131071) - 65536;
				w  = $urandom_range(0, 16383);
				h  = $urandom_range(0, 16383);
				px = $urandom_range(0, w + 64) - 32;
				py = $urandom_range(0, h + 64) - 32;
				// quadrant boundaries, where the sine folding turns over
				if (mode == 2) ang = $urandom_range(0, 5) * 90;
			end
		endcase
		send_rect(ax, ay, w, h, px, py, ang);
	endtask

	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);

		// all zero, then identity and the exact quarter turns
		send_rect(0, 0, 0, 0, 0, 0, 0);
		send_rect(100, -200, 160, 80, 0, 0, 0);
		send_rect(100, -200, 160, 80, 0, 0, 90);
		send_rect(100, -200, 160, 80, 0, 0, 180);
		send_rect(100, -200, 160, 80, 0, 0, 270);
		// sine of one half: odd offsets land exactly on a rounding tie
		send_rect(0, 0, 1, 1, 1, -1, 30);
		send_rect(0, 0, 3, 5, -1, 1, 150);
		send_rect(0, 0, 7, 3, 0, 0, 210);
		send_rect(0, 0, 9, 1, 0, 0, 330);
		// field extremes, corners clamp high and low
		send_rect(CMAX, CMAX, SMAX, SMAX, CMIN, CMIN, 0);
		send_rect(CMIN, CMIN, SMAX, SMAX, CMAX, CMAX, 0);
		send_rect(CMIN, CMAX, SMAX, 0, CMIN, CMAX, 45);
		send_rect(CMAX, CMIN, 0, SMAX, CMAX, CMIN, 135);
		send_rect(0, 0, SMAX, SMAX, CMAX, CMAX, 225);
		send_rect(0, 0, SMAX, SMAX, CMIN, CMIN, 315);
		// around the wrap and the quadrant edges, then angles past a turn
		send_rect(16, -16, 320, 160, 160, 80, 359);
		send_rect(16, -16, 320, 160, 160, 80, 360);
		send_rect(16, -16, 320, 160, 160, 80, 450);
		send_rect(16, -16, 320, 160, 160, 80, 511);
		send_rect(16, -16, 320, 160, 160, 80, 1);
		send_rect(16, -16, 320, 160, 160, 80, 89);
		send_rect(16, -16, 320, 160, 160, 80, 91);
		send_rect(-1, -1, 1, 1, -1, -1, 269);
		send_rect(0, 0, 0, 0, CMAX, CMIN, 271);
		send_rect(12345, -54321, 4000, 2000, 2000, 1000, 60);

		// random items, with one long back-to-back stretch in the middle
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			gaps_on = !(n >= 150 && n < 250);
			send_random_rect();
		end
		start <= 1'b0;

		// let the pipeline empty, then give late or extra results a chance
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
